### rtl/dfs_adjacency_matrix_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first search core.
// Each macro checks an implication on the core clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DFS_ADJACENCY_MATRIX_CORE_DEFINES_SVH
`define DFS_ADJACENCY_MATRIX_CORE_DEFINES_SVH

// Same-cycle implication.
`define DFSAM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfs core check failed");

// Next-cycle implication.
`define DFSAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfs core check failed");

`endif

### rtl/dfsam_pkg.sv
// ----------------------------------------------------------------------------
// dfsam_pkg
// Shared types and constants of the depth-first search core.
// ----------------------------------------------------------------------------
`default_nettype none

package dfsam_pkg;

    localparam int NODE_COUNT  = 64;
    localparam int NODE_W      = 6;
    localparam int DEPTH_W     = 7;
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_OFS_W = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] row_node;
        logic [NODE_W-1:0] col_node;
        logic              edge_bit;
        logic [NODE_W-1:0] start_node;
    } dfsam_req_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_id;
        logic [NODE_W-1:0]  parent_id;
        logic               has_parent;
        logic [DEPTH_W-1:0] max_path_nodes;
        logic               last;
    } dfsam_visit_t;

    // One stack frame: the node and the next neighbor index to examine.
    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [DEPTH_W-1:0] next;
    } dfsam_frame_t;

    typedef struct packed {
        logic                   hit;
        logic [GROUP_OFS_W-1:0] offset;
    } dfsam_scan_t;

endpackage

`default_nettype wire

### rtl/dfsam_adj_mem.sv
// ----------------------------------------------------------------------------
// dfsam_adj_mem
// Adjacency matrix, one row per node, with per-row valid bits for reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsam_adj_mem
    import dfsam_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [NODE_W-1:0]     wr_row,
    input  wire logic [NODE_W-1:0]     wr_col,
    input  wire logic                  wr_bit,
    input  wire logic                  rd_en,
    input  wire logic [NODE_W-1:0]     rd_row,
    output logic      [NODE_COUNT-1:0] rd_bits
);

    logic [NODE_COUNT-1:0] mem [0:NODE_COUNT-1];
    logic [NODE_COUNT-1:0] row_valid_reg;
    logic [NODE_COUNT-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    // A row never written since reset reads as all zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (row_valid_reg[wr_row])
            begin
                mem[wr_row][wr_col] <= wr_bit;
            end
            else
            begin
                mem[wr_row] <= {{(NODE_COUNT-1){1'b0}}, wr_bit} << wr_col;
            end
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_bits = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### rtl/dfsam_stack_mem.sv
// ----------------------------------------------------------------------------
// dfsam_stack_mem
// Walk stack holding the frames below the top of the traversal.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsam_stack_mem
    import dfsam_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [NODE_W-1:0] wr_addr,
    input  wire dfsam_frame_t      wr_data,
    input  wire logic              rd_en,
    input  wire logic [NODE_W-1:0] rd_addr,
    output dfsam_frame_t           rd_data
);

    dfsam_frame_t mem [0:NODE_COUNT-1];
    dfsam_frame_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/dfsam_scan_unit.sv
// ----------------------------------------------------------------------------
// dfsam_scan_unit
// Finds the lowest unvisited neighbor at or above start_ofs in one group of adjacency bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsam_scan_unit
    import dfsam_pkg::*;
(
    input  wire logic [GROUP_SIZE-1:0]  adj_bits,
    input  wire logic [GROUP_SIZE-1:0]  visited_bits,
    input  wire logic [GROUP_OFS_W-1:0] start_ofs,
    output dfsam_scan_t                 result
);

    logic [GROUP_SIZE-1:0] cand;

    always_comb
    begin
        cand   = adj_bits & ~visited_bits & ({GROUP_SIZE{1'b1}} << start_ofs);
        result = '0;
        // Walk from the top down so the lowest candidate wins.
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                result.hit    = 1'b1;
                result.offset = GROUP_OFS_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/dfs_adjacency_matrix_core.sv
// ----------------------------------------------------------------------------
// dfs_adjacency_matrix_core
// Depth-first traversal of a directed graph held as an adjacency matrix.
// ----------------------------------------------------------------------------
// Usage: the req channel carries load beats (cmd = load) that write one
// adjacency bit, and start beats (cmd = start) that walk the graph from
// start_node. A load beat gives no result. A start beat gives one visit beat
// per reached node, in depth-first order with neighbors taken in ascending
// index order; the root has has_parent low. The final beat has last high
// and carries the deepest stack seen (0 if only the root was reached). Each
// visit beat is held back one step so that last can be marked. req_stall is
// high from the start beat until the final visit beat is in the output
// register, so the core works on one traversal at a time. For each node the
// sequencer reads the row, scans the neighbor indexes in groups of eight
// with the shared scan unit, and pops the frame once its scan is done. Each
// return to a parent frame adds a stack read and a second row read, and the
// scan resumes at the index after the child. The visit register waits as
// long as visit_stall is high, and the sequencer pauses at its next visit
// beat. Reset clears the matrix (through per-row valid bits), the visited
// bits and all control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_adjacency_matrix_core_defines.svh"

module dfs_adjacency_matrix_core
    import dfsam_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_stall,
    input  wire dfsam_req_t req,
    output logic        visit_valid,
    input  wire logic   visit_stall,
    output dfsam_visit_t visit
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_RESTORE,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [NODE_COUNT-1:0] visited_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [DEPTH_W-1:0]    longest_reg;
    logic [NODE_W-1:0]     top_node_reg;
    logic [DEPTH_W-1:0]    scan_idx_reg;
    dfsam_visit_t          pend_reg;
    dfsam_visit_t          visit_reg;
    logic                  visit_valid_reg;

    logic                  req_accept;
    logic                  out_free;
    logic                  visit_load;
    logic [NODE_COUNT-1:0] adj_row;
    logic [NODE_W-1:0]     grp_base;
    dfsam_scan_t           scan_res;
    logic [NODE_W-1:0]     found_node;
    logic [DEPTH_W-1:0]    depth_inc;
    logic                  push;
    logic                  pop;
    logic [DEPTH_W-1:0]    push_addr_full;
    logic [DEPTH_W-1:0]    pop_addr_full;
    dfsam_frame_t          push_frame;
    dfsam_frame_t          restore_frame;

    assign req_stall   = (state_reg != ST_IDLE);
    assign req_accept  = req_valid && !req_stall;
    assign visit_valid = visit_valid_reg;
    assign visit       = visit_reg;

    // The visit register can take a new beat when empty or being drained.
    assign out_free = !visit_valid_reg || !visit_stall;

    // Scan window: group of eight neighbor indexes holding scan_idx_reg.
    assign grp_base   = {scan_idx_reg[NODE_W-1:GROUP_OFS_W], {GROUP_OFS_W{1'b0}}};
    assign found_node = {scan_idx_reg[NODE_W-1:GROUP_OFS_W], scan_res.offset};
    assign depth_inc  = depth_reg + DEPTH_W'(1);

    // Scan index bit NODE_W set means every neighbor of the top frame is done.
    assign push = (state_reg == ST_SCAN) && !scan_idx_reg[NODE_W] && scan_res.hit
                  && out_free;
    assign pop  = (state_reg == ST_SCAN) && scan_idx_reg[NODE_W];

    // A new beat enters the visit register on a push or at the end of a walk.
    assign visit_load = push || ((state_reg == ST_FINISH) && out_free);

    assign push_addr_full  = depth_reg - DEPTH_W'(1);
    assign pop_addr_full   = depth_reg - DEPTH_W'(2);
    assign push_frame.node = top_node_reg;
    assign push_frame.next = {1'b0, found_node} + DEPTH_W'(1);

    dfsam_adj_mem u_adj_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (req_accept && (req.cmd == CMD_LOAD)),
        .wr_row (req.row_node),
        .wr_col (req.col_node),
        .wr_bit (req.edge_bit),
        .rd_en  (state_reg == ST_FETCH),
        .rd_row (top_node_reg),
        .rd_bits(adj_row)
    );

    dfsam_stack_mem u_stack_mem (
        .clk    (clk),
        .wr_en  (push),
        .wr_addr(push_addr_full[NODE_W-1:0]),
        .wr_data(push_frame),
        .rd_en  (pop && (depth_reg != DEPTH_W'(1))),
        .rd_addr(pop_addr_full[NODE_W-1:0]),
        .rd_data(restore_frame)
    );

    dfsam_scan_unit u_scan_unit (
        .adj_bits    (adj_row[grp_base +: GROUP_SIZE]),
        .visited_bits(visited_reg[grp_base +: GROUP_SIZE]),
        .start_ofs   (scan_idx_reg[GROUP_OFS_W-1:0]),
        .result      (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            visited_reg     <= '0;
            depth_reg       <= '0;
            longest_reg     <= '0;
            top_node_reg    <= '0;
            scan_idx_reg    <= '0;
            pend_reg        <= '0;
            visit_reg       <= '0;
            visit_valid_reg <= 1'b0;
        end
        else
        begin
            if (visit_valid_reg && !visit_stall && !visit_load)
            begin
                visit_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept && (req.cmd == CMD_START))
                    begin
                        visited_reg  <= {{(NODE_COUNT-1){1'b0}}, 1'b1} << req.start_node;
                        depth_reg    <= DEPTH_W'(1);
                        longest_reg  <= '0;
                        top_node_reg <= req.start_node;
                        scan_idx_reg <= '0;
                        pend_reg.node_id        <= req.start_node;
                        pend_reg.parent_id      <= '0;
                        pend_reg.has_parent     <= 1'b0;
                        pend_reg.max_path_nodes <= '0;
                        pend_reg.last           <= 1'b0;
                        state_reg    <= ST_FETCH;
                    end
                end

                ST_FETCH:
                begin
                    state_reg <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    if (pop)
                    begin
                        depth_reg <= depth_reg - DEPTH_W'(1);
                        if (depth_reg == DEPTH_W'(1))
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_RESTORE;
                        end
                    end
                    else if (scan_res.hit)
                    begin
                        if (push)
                        begin
                            // Send the held beat and hold the new node back.
                            visit_reg       <= pend_reg;
                            visit_valid_reg <= 1'b1;
                            pend_reg.node_id    <= found_node;
                            pend_reg.parent_id  <= top_node_reg;
                            pend_reg.has_parent <= 1'b1;
                            visited_reg[found_node] <= 1'b1;
                            depth_reg    <= depth_inc;
                            if (depth_inc > longest_reg)
                            begin
                                longest_reg <= depth_inc;
                            end
                            top_node_reg <= found_node;
                            scan_idx_reg <= '0;
                            state_reg    <= ST_FETCH;
                        end
                    end
                    else
                    begin
                        scan_idx_reg <= {scan_idx_reg[DEPTH_W-1:GROUP_OFS_W]
                                         + (DEPTH_W - GROUP_OFS_W)'(1),
                                         {GROUP_OFS_W{1'b0}}};
                    end
                end

                ST_RESTORE:
                begin
                    top_node_reg <= restore_frame.node;
                    scan_idx_reg <= restore_frame.next;
                    state_reg    <= ST_FETCH;
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        visit_reg.node_id        <= pend_reg.node_id;
                        visit_reg.parent_id      <= pend_reg.parent_id;
                        visit_reg.has_parent     <= pend_reg.has_parent;
                        visit_reg.max_path_nodes <= longest_reg;
                        visit_reg.last           <= 1'b1;
                        visit_valid_reg          <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The deepest stack seen never trails the current depth once past the root.
    `DFSAM_ASSERT_NOW(a_longest_covers_depth, depth_reg > DEPTH_W'(1),
        longest_reg >= depth_reg)

    // The node whose neighbors are scanned is always marked visited.
    `DFSAM_ASSERT_NOW(a_top_visited, state_reg == ST_SCAN, visited_reg[top_node_reg])

    // Only the final beat of a traversal carries a depth figure.
    `DFSAM_ASSERT_NOW(a_depth_only_on_last, visit_valid_reg && !visit_reg.last,
        visit_reg.max_path_nodes == '0)

    // A push always leads to a row read for the new top node.
    `DFSAM_ASSERT_NEXT(a_push_fetches, push, state_reg == ST_FETCH)

endmodule

`default_nettype wire

### test/dfsam_visit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfsam_visit_checker
// Watches both channels of the depth-first search core, keeps its own copy
// of the adjacency matrix, predicts the visit beats of every start beat and
// compares each accepted visit beat with the oldest prediction.
// ----------------------------------------------------------------------------
module dfsam_visit_checker
    import dfsam_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         req_stall,
    input  dfsam_req_t   req,
    input  logic         visit_valid,
    input  logic         visit_stall,
    input  dfsam_visit_t visit,
    output int           fail_count,
    output int           pending
);

    logic [NODE_COUNT-1:0] adj_rows [NODE_COUNT];
    dfsam_visit_t          expected_visits [$];

    initial fail_count = 0;
    initial pending = 0;

    task automatic report_field(input string name, input int want, input int got);
        begin
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        end
    endtask

    // Iterative walk with an explicit frame stack. Each visit is held back
    // until the next one is known so that the final one can carry last and
    // the deepest stack seen.
    task automatic predict_walk(input logic [NODE_W-1:0] root);
        logic [NODE_COUNT-1:0] seen;
        logic [NODE_W-1:0]     frame_node [NODE_COUNT];
        int                    frame_next [NODE_COUNT];
        int                    depth;
        int                    longest;
        int                    scan;
        logic [NODE_W-1:0]     here;
        dfsam_visit_t          held;
        begin
            seen       = '0;
            seen[root] = 1'b1;
            frame_node[0] = root;
            frame_next[0] = 0;
            depth   = 1;
            longest = 0;
            held         = '0;
            held.node_id = root;
            while (depth > 0) begin
                here = frame_node[depth-1];
                scan = frame_next[depth-1];
                while (scan < NODE_COUNT && (seen[scan] || !adj_rows[here][scan]))
                    scan++;
                if (scan < NODE_COUNT && depth < NODE_COUNT) begin
                    frame_next[depth-1] = scan + 1;
                    seen[scan]          = 1'b1;
                    frame_node[depth]   = NODE_W'(scan);
                    frame_next[depth]   = 0;
                    depth++;
                    if (depth > longest)
                        longest = depth;
                    expected_visits = {expected_visits, held};
                    held            = '0;
                    held.node_id    = NODE_W'(scan);
                    held.parent_id  = here;
                    held.has_parent = 1'b1;
                end
                else begin
                    depth--;
                end
            end
            held.max_path_nodes = DEPTH_W'(longest);
            held.last           = 1'b1;
            expected_visits = {expected_visits, held};
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        dfsam_visit_t want;
        if (!rst_n) begin
            for (int r = 0; r < NODE_COUNT; r++)
                adj_rows[r] = '0;
            expected_visits.delete();
            pending = 0;
        end
        else begin
            if (visit_valid && !visit_stall) begin
                if (expected_visits.size() == 0) begin
                    $error("visit beat with no prediction waiting: node_id %0d",
                           visit.node_id);
                    fail_count++;
                end
                else begin
                    want = expected_visits.pop_front();
                    report_field("node_id", want.node_id, visit.node_id);
                    report_field("parent_id", want.parent_id, visit.parent_id);
                    report_field("has_parent", want.has_parent, visit.has_parent);
                    report_field("max_path_nodes", want.max_path_nodes,
                                 visit.max_path_nodes);
                    report_field("last", want.last, visit.last);
                end
            end
            if (req_valid && !req_stall) begin
                if (req.cmd == CMD_LOAD)
                    adj_rows[req.row_node][req.col_node] = req.edge_bit;
                else
                    predict_walk(req.start_node);
            end
            pending = expected_visits.size();
        end
    end

endmodule

### test/tb_dfs_adjacency_matrix_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dfs_adjacency_matrix_core
// Drives load and start beats into the depth-first search core with random
// gaps and random output stalls; a checker beside the core predicts and
// compares every visit beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dfs_adjacency_matrix_core;
    import dfsam_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung.
    // A dense traversal can pop back through a long stack between visit beats,
    // and the drain at the end waits well under this limit.
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 800;
    localparam int RANDOM_ITEMS = 240;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         req_valid = 1'b0;
    logic         req_stall;
    dfsam_req_t   req = '0;
    logic         visit_valid;
    logic         visit_stall = 1'b0;
    dfsam_visit_t visit;

    int fail_count;
    int pending;

    // When set, the sender issues beats back to back with no gaps.
    logic send_quiet = 1'b0;
    int   random_sent = 0;

    always #10 clk = ~clk;

    dfs_adjacency_matrix_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .visit_valid (visit_valid),
        .visit_stall (visit_stall),
        .visit       (visit)
    );

    dfsam_visit_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .visit_valid (visit_valid),
        .visit_stall (visit_stall),
        .visit       (visit),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Load beat. The start_node field is ignored by the core on a load, so it
    // carries random bits to make sure they really are ignored.
    function automatic dfsam_req_t make_load(input int row, input int col, input int bit_val);
        dfsam_req_t item;
        begin
            item            = '0;
            item.cmd        = CMD_LOAD;
            item.row_node   = NODE_W'(row);
            item.col_node   = NODE_W'(col);
            item.edge_bit   = bit_val[0];
            item.start_node = NODE_W'($urandom);
            return item;
        end
    endfunction

    // Start beat. The load fields are don't-care here and get random bits.
    function automatic dfsam_req_t make_start(input int root);
        dfsam_req_t item;
        begin
            item            = '0;
            item.cmd        = CMD_START;
            item.row_node   = NODE_W'($urandom);
            item.col_node   = NODE_W'($urandom);
            item.edge_bit   = 1'(($urandom));
            item.start_node = NODE_W'(root);
            return item;
        end
    endfunction

    // Presents one beat and returns at the edge where it is accepted. With a
    // zero gap, valid stays high from the previous beat, so it gets only one
    // assignment in that step.
    task automatic send_beat(input dfsam_req_t item);
        int gap;
        begin
            gap = send_quiet ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req_valid <= 1'b1;
            req       <= item;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
        end
    endtask

    // The receiver draws a stall length for every accepted visit beat. Now
    // and then it switches to a quiet spell in which it never stalls.
    int   stall_left = 0;
    int   stall_beats = 0;
    logic stall_quiet = 1'b0;

    always @(posedge clk) begin
        if (visit_valid && !visit_stall) begin
            stall_beats++;
            if (stall_beats % 37 == 0)
                stall_quiet = ($urandom_range(0, 2) == 0);
            stall_left = stall_quiet ? 0 : $urandom_range(0, 18);
            visit_stall <= (stall_left != 0);
        end
        else if (stall_left > 0) begin
            stall_left--;
            visit_stall <= (stall_left != 0);
        end
    end

    // The watchdog ends the run if neither channel moves a beat for too long.
    int idle_cycles = 0;

    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (visit_valid && !visit_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $error("no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int load_count;
        int base;
        int span;
        int pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A start on the empty graph reaches only the root,
        // which must report a depth of zero; the same holds for the highest
        // node index.
        send_beat(make_start(0));
        send_beat(make_start(63));
        // A self loop is skipped, so the root is still alone.
        send_beat(make_load(5, 5, 1));
        send_beat(make_start(5));
        // The corner edges of the matrix; the edge back to the root points at
        // a node that is already visited.
        send_beat(make_load(0, 63, 1));
        send_beat(make_load(63, 0, 1));
        send_beat(make_start(0));
        // Ascending neighbor order: node 1 must come before node 63.
        send_beat(make_load(63, 62, 1));
        send_beat(make_load(0, 1, 1));
        send_beat(make_load(1, 63, 1));
        send_beat(make_start(0));
        send_beat(make_start(62));
        // Writing a zero removes an edge.
        send_beat(make_load(0, 63, 0));
        send_beat(make_load(1, 63, 0));
        send_beat(make_start(0));
        send_beat(make_load(63, 63, 0));
        send_beat(make_start(63));

        // A chain through every node gives the deepest possible stack.
        send_quiet = 1'b1;
        for (int n = 0; n < NODE_COUNT - 1; n++)
            send_beat(make_load(n, n + 1, 1));
        send_quiet = 1'b0;
        send_beat(make_start(0));
        send_beat(make_start(32));

        // Random part. Each round writes a burst of edges into a window of
        // nodes and then usually walks from a node in that window. A few
        // loads land anywhere, some remove edges, and some rounds end
        // without a start at all.
        while (random_sent < RANDOM_ITEMS) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            span = $urandom_range(2, NODE_COUNT);
            base = $urandom_range(0, NODE_COUNT - span);
            load_count = $urandom_range(1, 12);
            for (int k = 0; k < load_count; k++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_beat(make_load($urandom_range(0, 63), $urandom_range(0, 63),
                                        $urandom_range(0, 1)));
                else
                    send_beat(make_load(base + $urandom_range(0, span - 1),
                                        base + $urandom_range(0, span - 1),
                                        (pick < 7) ? 1 : 0));
                random_sent++;
            end
            if ($urandom_range(0, 5) != 0) begin
                if ($urandom_range(0, 4) == 0)
                    send_beat(make_start($urandom_range(0, 63)));
                else
                    send_beat(make_start(base + $urandom_range(0, span - 1)));
                random_sent++;
            end
        end
        req_valid <= 1'b0;
        // Let the checker count the predictions of the last beat before the
        // pending count is read.
        @(posedge clk);

        // Let every predicted visit beat arrive, then give the core time to
        // show any stray beat.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $error("%0d predicted visit beats never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
